FILE: sv/msr_pkg.sv
package msr_pkg;
    localparam int unsigned PRIME_BITS = 32;
    localparam int unsigned PW = PRIME_BITS;
    localparam int unsigned PROD_W = 2 * PW;
    localparam int unsigned CNT_W = $clog2(PW + 1);
    localparam int unsigned ZSEARCH_LIMIT = 1024;
    localparam int unsigned ZK_W = $clog2(ZSEARCH_LIMIT + 1);

    typedef logic [PW-1:0] t_word;

    typedef struct packed {
        logic  start;
        t_word a;
        t_word b;
        t_word m;
    } t_mm_req;

    typedef struct packed {
        logic  done;
        t_word prod;
    } t_mm_rsp;
endpackage

FILE: sv/msr_modmul.sv
module msr_modmul (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  msr_pkg::t_mm_req i_req,
    output msr_pkg::t_mm_rsp o_rsp
);
    import msr_pkg::*;

    // Shift-add multiply with reduction, one multiplier bit per cycle, MSB first.
    logic [PW-1:0]  r_acc, n_acc;
    logic [PW-1:0]  r_a, r_b, r_m;
    logic [CNT_W-1:0] r_cnt;
    logic           r_busy, r_done;
    logic [PW+1:0]  dbl, dbl_red, add, add_red;

    always_comb begin
        dbl     = {1'b0, r_acc, 1'b0};
        dbl_red = (dbl >= {2'b00, r_m}) ? dbl - {2'b00, r_m} : dbl;
        add     = dbl_red + (r_b[PW-1] ? {2'b00, r_a} : '0);
        add_red = (add >= {2'b00, r_m}) ? add - {2'b00, r_m} : add;
        n_acc   = add_red[PW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(PW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= (i_req.a >= i_req.m) ? i_req.a - i_req.m : i_req.a;
            r_b   <= i_req.b;
            r_m   <= i_req.m;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= {r_b[PW-2:0], 1'b0};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;
endmodule

FILE: sv/modular_square_root.sv
// Latency: data dependent; each modular multiply is issued, runs over the 32 multiplier
// bits and is handed back; a 3-mod-4 prime needs up to about 64 multiplies, a
// Tonelli-Shanks prime up to about 1k, and a composite modulus whose non-residue
// search runs to its 1024-candidate limit about 64k.
// Throughput: one request at a time; input is taken only while the sequencer is idle,
// and every multiply runs on the shared bit-serial multiplier (one bit per cycle).
// Reset: synchronous, active low; clears the sequencer and the output valid.
module modular_square_root (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [31:0]         i_value_n,
    input  logic [31:0]         i_prime_p,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [31:0]         o_root,
    output logic                o_not_residue
);
    import msr_pkg::*;

    // Sequencer states
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DISP   = 5'd1;
    localparam logic [4:0] S_NRED   = 5'd2;   // n mod p via 1*n
    localparam logic [4:0] S_PSTART = 5'd3;   // start exponentiation, reduce base
    localparam logic [4:0] S_PSTEP  = 5'd4;   // pick next multiply
    localparam logic [4:0] S_PWAIT  = 5'd5;
    localparam logic [4:0] S_ZCHK   = 5'd6;
    localparam logic [4:0] S_TS_C   = 5'd7;
    localparam logic [4:0] S_TS_T   = 5'd8;
    localparam logic [4:0] S_PBASE  = 5'd9;   // take reduced base, seed accumulator
    localparam logic [4:0] S_LOOP   = 5'd10;
    localparam logic [4:0] S_SQ     = 5'd11;
    localparam logic [4:0] S_BSQ    = 5'd12;
    localparam logic [4:0] S_BB     = 5'd13;
    localparam logic [4:0] S_RB     = 5'd14;
    localparam logic [4:0] S_TBB    = 5'd15;
    localparam logic [4:0] S_OUT    = 5'd16;
    localparam logic [4:0] S_MWAIT  = 5'd17;

    // Exponentiation purposes
    localparam logic [2:0] P_ROOT3 = 3'd0;
    localparam logic [2:0] P_ZTEST = 3'd1;
    localparam logic [2:0] P_C     = 3'd2;
    localparam logic [2:0] P_T     = 3'd3;
    localparam logic [2:0] P_R     = 3'd4;

    logic [4:0]  r_state, r_ret;
    logic [2:0]  r_purp;
    t_word       r_n, r_p, r_q;
    logic [CNT_W-1:0] r_s, r_m, r_i, r_j;
    t_word       r_c, r_t, r_r, r_b, r_sq, r_bb;
    t_word       r_acc, r_base, r_exp, r_res;
    logic        r_pmul;      // 0: acc*base pending, 1: base*base pending
    logic [ZK_W-1:0] r_zk;
    logic        r_valid;
    t_word       r_root;
    logic        r_flag;
    // Output register: hold a waiting result while the next request runs.
    t_word       r_oroot;
    logic        r_oflag;

    t_mm_req mm_req;
    t_mm_rsp mm_rsp;

    msr_modmul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mm_req),
        .o_rsp   (mm_rsp)
    );

    // Drive the multiplier from a registered request.
    t_word r_ma, r_mb;
    logic  r_mstart;
    assign mm_req.start = r_mstart;
    assign mm_req.a     = r_ma;
    assign mm_req.b     = r_mb;
    assign mm_req.m     = r_p;

    wire accept = i_valid && !o_stall;
    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_root        = r_oroot;
    assign o_not_residue = r_oflag;

    wire t_word pm1 = r_p - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= 1'b0;
            r_mstart <= 1'b0;
        end else begin
            r_mstart <= 1'b0;
            if (r_valid && !i_stall) r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_n     <= i_value_n;
                        r_p     <= i_prime_p;
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    r_flag <= 1'b0;
                    r_root <= '0;
                    if (r_p < 2) begin
                        r_state <= S_OUT;
                    end else if (r_p == 2) begin
                        r_root  <= {{(PW-1){1'b0}}, r_n[0]};
                        r_state <= S_OUT;
                    end else begin
                        // reduce n first; n rides on the multiplier bits
                        r_ma <= PW'(1); r_mb <= r_n; r_mstart <= 1'b1;
                        r_ret <= S_NRED; r_state <= S_MWAIT;
                        r_q <= pm1; r_s <= '0;
                    end
                end
                S_MWAIT: begin
                    if (mm_rsp.done) begin
                        r_res   <= mm_rsp.prod;
                        r_state <= r_ret;
                    end
                end
                S_NRED: begin
                    r_n <= r_res;
                    if (r_p[1:0] == 2'b11) begin
                        r_base <= r_res;
                        r_exp  <= (r_p >> 2) + 1'b1;
                        r_purp <= P_ROOT3;
                        r_state <= S_PSTART;
                    end else if (!r_q[0]) begin
                        // strip factors of two from p-1, one per pass
                        r_q <= r_q >> 1; r_s <= r_s + 1'b1;
                        r_state <= S_NRED;
                    end else begin
                        r_zk   <= '0;
                        r_base <= PW'(2);
                        r_exp  <= pm1 >> 1;
                        r_purp <= P_ZTEST;
                        r_state <= S_PSTART;
                    end
                end
                S_PSTART: begin
                    // reduce the base modulo p before squaring it
                    r_ma <= PW'(1); r_mb <= r_base; r_mstart <= 1'b1;
                    r_ret <= S_PBASE; r_state <= S_MWAIT;
                end
                S_PBASE: begin
                    r_base  <= r_res;
                    r_acc   <= PW'(1);
                    r_pmul  <= 1'b0;
                    r_state <= S_PSTEP;
                end
                S_PSTEP: begin
                    if (r_exp == '0) begin
                        unique case (r_purp)
                            P_ROOT3: begin r_root <= r_acc; r_state <= S_OUT; end
                            P_ZTEST: r_state <= S_ZCHK;
                            P_C: begin
                                r_c <= r_acc; r_base <= r_n; r_exp <= r_q;
                                r_purp <= P_T; r_state <= S_PSTART;
                            end
                            P_T: begin
                                r_t <= r_acc; r_base <= r_n;
                                r_exp <= (r_q >> 1) + 1'b1;
                                r_purp <= P_R; r_state <= S_PSTART;
                            end
                            default: begin
                                r_r <= r_acc; r_m <= r_s; r_state <= S_LOOP;
                            end
                        endcase
                    end else if (r_exp[0] && !r_pmul) begin
                        r_ma <= r_acc; r_mb <= r_base; r_mstart <= 1'b1;
                        r_ret <= S_PWAIT; r_state <= S_MWAIT;
                    end else begin
                        r_ma <= r_base; r_mb <= r_base; r_mstart <= 1'b1;
                        r_pmul <= 1'b1;
                        r_ret <= S_PWAIT; r_state <= S_MWAIT;
                    end
                end
                S_PWAIT: begin
                    if (r_pmul) begin
                        r_base <= r_res; r_exp <= r_exp >> 1; r_pmul <= 1'b0;
                    end else begin
                        r_acc <= r_res; r_pmul <= 1'b1;
                    end
                    r_state <= S_PSTEP;
                end
                S_ZCHK: begin
                    if (r_acc == pm1) begin
                        // non-residue found: z = 2 + k
                        r_base <= PW'(2) + PW'(r_zk);
                        r_exp <= r_q; r_purp <= P_C; r_state <= S_PSTART;
                    end else if (r_zk == ZK_W'(ZSEARCH_LIMIT - 1)) begin
                        r_flag <= 1'b1; r_state <= S_OUT;
                    end else begin
                        r_zk <= r_zk + 1'b1;
                        r_base <= PW'(3) + PW'(r_zk);
                        r_exp <= pm1 >> 1; r_purp <= P_ZTEST;
                        r_state <= S_PSTART;
                    end
                end
                S_LOOP: begin
                    if (r_t == PW'(1)) begin
                        r_root <= r_r; r_state <= S_OUT;
                    end else if (r_t == '0) begin
                        r_root <= '0; r_state <= S_OUT;
                    end else begin
                        r_sq <= r_t; r_i <= '0; r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (r_sq != PW'(1) && r_i < r_m) begin
                        r_ma <= r_sq; r_mb <= r_sq; r_mstart <= 1'b1;
                        r_i <= r_i + 1'b1; r_ret <= S_TS_C; r_state <= S_MWAIT;
                    end else if (r_i == r_m) begin
                        r_root <= '0; r_flag <= 1'b1; r_state <= S_OUT;
                    end else begin
                        r_b <= r_c; r_j <= '0; r_state <= S_BSQ;
                    end
                end
                S_TS_C: begin
                    r_sq <= r_res; r_state <= S_SQ;
                end
                S_BSQ: begin
                    if ((CNT_W+1)'(r_j) + (CNT_W+1)'(r_i) + 1'b1 < (CNT_W+1)'(r_m)) begin
                        r_ma <= r_b; r_mb <= r_b; r_mstart <= 1'b1;
                        r_j <= r_j + 1'b1; r_ret <= S_TS_T; r_state <= S_MWAIT;
                    end else begin
                        r_ma <= r_b; r_mb <= r_b; r_mstart <= 1'b1;
                        r_ret <= S_BB; r_state <= S_MWAIT;
                    end
                end
                S_TS_T: begin
                    r_b <= r_res; r_state <= S_BSQ;
                end
                S_BB: begin
                    r_bb <= r_res;
                    r_ma <= r_r; r_mb <= r_b; r_mstart <= 1'b1;
                    r_ret <= S_RB; r_state <= S_MWAIT;
                end
                S_RB: begin
                    r_r <= r_res;
                    r_ma <= r_t; r_mb <= r_bb; r_mstart <= 1'b1;
                    r_ret <= S_TBB; r_state <= S_MWAIT;
                end
                S_TBB: begin
                    r_t <= r_res; r_c <= r_bb; r_m <= r_i;
                    r_state <= S_LOOP;
                end
                S_OUT: begin
                    // hold until the previous result has left the output register
                    if (!r_valid) begin
                        r_valid <= 1'b1;
                        r_oroot <= r_root;
                        r_oflag <= r_flag;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("busy without stall");
    a_flag_zero_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_not_residue) |-> (o_root == '0))
        else $error("flagged result with nonzero root");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_root)))
        else $error("stalled result changed");
    a_mul_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mstart |-> (r_state == S_MWAIT))
        else $error("multiply started outside wait");
`endif
endmodule

FILE: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] value_n;
        logic [31:0] prime_p;
    } t_sqrt_req;

    typedef struct {
        logic [31:0] root;
        logic        not_residue;
    } t_sqrt_ans;

    // Idle pattern: sender sparse/receiver heavy, then swapped, then none.
    typedef enum logic [1:0] {
        IDLE_RX_HEAVY,
        IDLE_TX_HEAVY,
        IDLE_NONE
    } t_idle_mode;

    localparam int unsigned RANDOM_ITEMS = 600;
    localparam int unsigned STALL_LIMIT  = 20000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_value_n = '0;
    logic [31:0] i_prime_p = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_root;
    logic        o_not_residue;

    t_sqrt_req   pending_reqs[$];
    t_sqrt_ans   expected_roots[$];
    int unsigned total_reqs = 0;
    int unsigned issued_reqs = 0;
    int unsigned error_count = 0;
    int unsigned quiet_cycles = 0;
    bit          req_taken = 1'b0;
    bit          run_live = 1'b0;

    modular_square_root dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_value_n     (i_value_n),
        .i_prime_p     (i_prime_p),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_root        (o_root),
        .o_not_residue (o_not_residue)
    );

    always #5 i_clk = ~i_clk;

    // Modular arithmetic on operands below 2^32; products fit in 64 bits.
    function automatic longint unsigned mulmod(longint unsigned a, longint unsigned b,
                                               longint unsigned m);
        return (a * b) % m;
    endfunction

    function automatic longint unsigned powmod(longint unsigned base, longint unsigned e,
                                               longint unsigned m);
        longint unsigned acc;
        acc = 1 % m;
        base = base % m;
        while (e != 0) begin
            if (e[0]) acc = mulmod(acc, base, m);
            base = mulmod(base, base, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    // Deterministic Miller-Rabin for 32-bit values (bases 2, 7, 61).
    function automatic bit is_prime32(longint unsigned p);
        longint unsigned d;
        longint unsigned x;
        longint unsigned bases[3];
        int              s;
        int              i;
        int              r;
        bit              witness;
        bases = '{2, 7, 61};
        if (p < 2) return 0;
        if (p == 2 || p == 3 || p == 7 || p == 61) return 1;
        if (p % 2 == 0) return 0;
        d = p - 1;
        s = 0;
        while (d % 2 == 0) begin
            d = d / 2;
            s++;
        end
        for (i = 0; i < 3; i++) begin
            x = powmod(bases[i], d, p);
            if (x == 1 || x == p - 1) continue;
            witness = 1;
            for (r = 1; r < s; r++) begin
                x = mulmod(x, x, p);
                if (x == p - 1) begin
                    witness = 0;
                    break;
                end
            end
            if (witness) return 0;
        end
        return 1;
    endfunction

    // Square root modulo p: zero for p < 2, low bit for p = 2, a single power for p = 3 mod 4,
    // Tonelli-Shanks otherwise, with a bounded search for a non-residue.
    function automatic t_sqrt_ans predict_root(t_sqrt_req req);
        t_sqrt_ans       ans;
        longint unsigned n;
        longint unsigned p;
        longint unsigned q;
        longint unsigned s;
        longint unsigned z;
        longint unsigned m;
        longint unsigned c;
        longint unsigned t;
        longint unsigned r;
        longint unsigned i;
        longint unsigned sq;
        longint unsigned b;
        longint unsigned bb;
        longint unsigned j;
        longint unsigned k;
        bit              found;
        n = req.value_n;
        p = req.prime_p;
        ans.root = '0;
        ans.not_residue = 1'b0;
        if (p < 2) begin
            ans.root = '0;
        end else if (p == 2) begin
            ans.root = 32'(n & 1);
        end else if ((p & 3) == 3) begin
            ans.root = 32'(powmod(n, (p + 1) / 4, p));
        end else begin
            q = p - 1;
            s = 0;
            while ((q & 1) == 0) begin
                q = q >> 1;
                s++;
            end
            found = 0;
            z = 0;
            for (k = 0; k < msr_pkg::ZSEARCH_LIMIT; k++) begin
                if (powmod(2 + k, (p - 1) / 2, p) == p - 1) begin
                    z = 2 + k;
                    found = 1;
                    break;
                end
            end
            if (!found) begin
                ans.not_residue = 1'b1;
            end else begin
                m = s;
                c = powmod(z, q, p);
                t = powmod(n, q, p);
                r = powmod(n, (q + 1) / 2, p);
                while (1) begin
                    if (t == 1) begin
                        ans.root = 32'(r);
                        break;
                    end
                    if (t == 0) begin
                        ans.root = '0;
                        break;
                    end
                    i = 0;
                    sq = t;
                    while (sq != 1 && i < m) begin
                        sq = mulmod(sq, sq, p);
                        i++;
                    end
                    if (i == m) begin
                        ans.root = '0;
                        ans.not_residue = 1'b1;
                        break;
                    end
                    b = c;
                    for (j = 0; j + i + 1 < m; j++) b = mulmod(b, b, p);
                    bb = mulmod(b, b, p);
                    r = mulmod(r, b, p);
                    t = mulmod(t, bb, p);
                    c = bb;
                    m = i;
                end
            end
        end
        return ans;
    endfunction

    function automatic longint unsigned random_prime(bit three_mod_four, int unsigned bits);
        longint unsigned p;
        do begin
            p = {$urandom, $urandom} & ((64'd1 << bits) - 1);
            p[bits-1] = 1'b1;
            p[1:0] = three_mod_four ? 2'b11 : 2'b01;
        end while (!is_prime32(p));
        return p;
    endfunction

    function automatic t_idle_mode idle_mode_now();
        if (issued_reqs < total_reqs / 3) return IDLE_RX_HEAVY;
        if (issued_reqs < 2 * total_reqs / 3) return IDLE_TX_HEAVY;
        return IDLE_NONE;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got %0h, expected %0h (t=%0t)", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic add_req(logic [31:0] n, logic [31:0] p);
        t_sqrt_req req;
        req.value_n = n;
        req.prime_p = p;
        pending_reqs.push_back(req);
    endtask

    // Monitor: log accepted requests, check accepted results, watch for a hang.
    always @(posedge i_clk) begin
        t_sqrt_req req;
        t_sqrt_ans want;
        bit        moved;
        moved = 1'b0;
        req_taken = 1'b0;
        if (i_rst_n && i_valid && !o_stall) begin
            req.value_n = i_value_n;
            req.prime_p = i_prime_p;
            expected_roots.push_back(predict_root(req));
            req_taken = 1'b1;
            moved = 1'b1;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            moved = 1'b1;
            if (expected_roots.size() == 0) begin
                report_mismatch("unexpected result", o_root, '0);
            end else begin
                want = expected_roots.pop_front();
                if (o_root !== want.root) report_mismatch("root", o_root, want.root);
                if (o_not_residue !== want.not_residue)
                    report_mismatch("not_residue", 32'(o_not_residue),
                                    32'(want.not_residue));
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog expired with %0d results pending", expected_roots.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Driver: hold a request until taken, then advance with random idling.
    always @(negedge i_clk) begin
        t_sqrt_req  req;
        t_idle_mode mode;
        int unsigned tx_idle;
        int unsigned rx_idle;
        mode = idle_mode_now();
        tx_idle = (mode == IDLE_RX_HEAVY) ? 8 : (mode == IDLE_TX_HEAVY) ? 82 : 0;
        rx_idle = (mode == IDLE_RX_HEAVY) ? 82 : (mode == IDLE_TX_HEAVY) ? 8 : 0;
        if (run_live) begin
            if (!i_valid || req_taken) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= tx_idle) begin
                    req = pending_reqs.pop_front();
                    i_value_n <= req.value_n;
                    i_prime_p <= req.prime_p;
                    i_valid <= 1'b1;
                    issued_reqs++;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_stall <= ($urandom_range(99) < rx_idle);
        end
    end

    initial begin
        longint unsigned p;
        longint unsigned x;
        longint unsigned n;
        int unsigned     sel;
        int unsigned     idx;

        // Directed: degenerate moduli, p = 2, extremes, deep 2-adic primes,
        // non-residues and a few composite moduli.
        add_req(32'd5, 32'd0);
        add_req(32'hFFFFFFFF, 32'd1);
        add_req(32'd3, 32'd2);
        add_req(32'hFFFFFFFE, 32'd2);
        add_req(32'd0, 32'd4294967291);
        add_req(32'hFFFFFFFF, 32'd4294967291);
        add_req(32'd4, 32'd4294967291);
        add_req(32'd10, 32'd13);
        add_req(32'd2, 32'd13);
        add_req(32'd26, 32'd13);
        add_req(32'd10, 32'd17);
        add_req(32'd3, 32'd17);
        add_req(32'd12345, 32'd65537);
        add_req(32'd9, 32'd3221225473);
        add_req(32'hDEADBEEF, 32'd2013265921);
        add_req(32'h12345678, 32'd4293918721);
        add_req(32'hFFFFFFFF, 32'd4293918721);
        add_req(32'd5, 32'd9);
        add_req(32'd7, 32'd15);
        add_req(32'd123, 32'd4);
        add_req(32'hFFFFFFFF, 32'hFFFFFFFF);
        add_req(32'd0, 32'd7);

        // Random: mostly primes with planted residues so Tonelli-Shanks iterates.
        for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
            sel = $urandom_range(99);
            if (sel < 3) begin
                p = $urandom_range(2);
            end else if (sel < 40) begin
                p = random_prime(1, $urandom_range(3) == 0 ? $urandom_range(31, 4) : 32);
            end else if (sel < 92) begin
                p = random_prime(0, $urandom_range(3) == 0 ? $urandom_range(31, 4) : 32);
            end else begin
                // cheap composites only: 3 mod 4 skips the non-residue search
                p = {$urandom} | 32'd3;
                if (is_prime32(p)) p = 32'hFFFFFFFF;
            end
            if (p >= 3 && $urandom_range(99) < 60) begin
                x = $urandom % p;
                n = mulmod(x, x, p);
                if ($urandom_range(1) && n + p <= 64'hFFFFFFFF) n = n + p;
            end else begin
                n = $urandom;
            end
            add_req(n[31:0], p[31:0]);
        end
        total_reqs = pending_reqs.size();

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_live = 1'b1;

        // Drain: wait for all requests and results, then let things settle.
        wait (pending_reqs.size() == 0 && !i_valid && expected_roots.size() == 0);
        repeat (200) @(posedge i_clk);
        if (error_count == 0 && expected_roots.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
